### hw/rtl/ksel_pkg.sv
package ksel_pkg;

  localparam int unsigned MAX_POINTS_DEF  = 1024;
  localparam int unsigned MAX_STENCIL_DEF = 64;
  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned SIZE_W          = 7;
  localparam int unsigned RAD_W           = 35;
  localparam logic [RAD_W-1:0] RAD_RESET  = '1;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic {
    CFG_SIZE   = 1'b0,
    CFG_RADIUS = 1'b1
  } cfg_e;

  typedef enum logic [1:0] {
    DOP_IDLE,
    DOP_FIRST,
    DOP_NEXT,
    DOP_LAST
  } dist_op_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  typedef struct packed {
    dist_op_e op;
    axis_e    axis;
  } dist_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_CEN,
    S_SC_RD,
    S_SC_X,
    S_SC_Y,
    S_SC_Z,
    S_SC_S,
    S_SC_CHK,
    S_TAIL,
    S_INS_RD,
    S_INS_CMP,
    S_EM_RD,
    S_EM_CHK
  } state_e;

endpackage

### hw/rtl/ksel_dist.sv
module ksel_dist #(
  parameter int unsigned COORD_BITS = ksel_pkg::COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ksel_pkg::dist_ctrl_t      ctrl_i,
  input  logic [3*COORD_BITS-1:0]   pt_i,
  input  logic [3*COORD_BITS-1:0]   cen_i,
  output logic [2*COORD_BITS+1:0]   dist_o
);
  import ksel_pkg::*;

  localparam int unsigned DIST_W = 2*COORD_BITS+2;

  logic signed [COORD_BITS-1:0] a, b;
  logic signed [COORD_BITS:0]   diff;
  logic [COORD_BITS-1:0]        mag;
  logic [2*COORD_BITS-1:0]      sq;
  logic [DIST_W-1:0]            prod_q, acc_q;

  always_comb begin
    case (ctrl_i.axis)
      AX_Y: begin
        a = pt_i[2*COORD_BITS-1:COORD_BITS];
        b = cen_i[2*COORD_BITS-1:COORD_BITS];
      end
      AX_Z: begin
        a = pt_i[3*COORD_BITS-1:2*COORD_BITS];
        b = cen_i[3*COORD_BITS-1:2*COORD_BITS];
      end
      default: begin
        a = pt_i[COORD_BITS-1:0];
        b = cen_i[COORD_BITS-1:0];
      end
    endcase
    diff = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
    // magnitude always fits COORD_BITS unsigned bits
    mag  = diff[COORD_BITS] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
    sq   = mag * mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      case (ctrl_i.op)
        DOP_FIRST: begin
          prod_q <= DIST_W'(sq);
          acc_q  <= '0;
        end
        DOP_NEXT: begin
          prod_q <= DIST_W'(sq);
          acc_q  <= acc_q + prod_q;
        end
        DOP_LAST: acc_q <= acc_q + prod_q;
        default: ;
      endcase
    end
  end

  assign dist_o = acc_q;

endmodule

### hw/rtl/knn_stencil_select.sv
// channel  | handshake               | payload
// in       | in_valid_i / in_ready_o | req_type_i center_index_i coord_x_i coord_y_i coord_z_i
// out      | out_valid_o/out_ready_i | neighbor_index_o neighbor_dist_sq_o status_o last_o
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
// Append, clear and rejected query: through S_RESP to the output register.
// Query: per stored point S_SC_RD, S_SC_X/Y/Z, S_SC_S, S_SC_CHK through the shared squaring
// unit (centre: S_SC_RD only), plus S_TAIL for the tail compare once the list is full, plus
// S_INS_RD and S_INS_CMP per list shift on insertion, plus S_EM_RD and S_EM_CHK per emitted beat.
// Reset clears the state, the point count, the configuration and the valid flags; no clearing pass.
// A stalled output holds the sequencer; no new beat is taken until idle.
module knn_stencil_select #(
  parameter int unsigned MAX_POINTS  = ksel_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_STENCIL = ksel_pkg::MAX_STENCIL_DEF,
  parameter int unsigned COORD_BITS  = ksel_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         req_type_i,
  input  logic [$clog2(MAX_POINTS)-1:0]      center_index_i,
  input  logic signed [COORD_BITS-1:0]       coord_x_i,
  input  logic signed [COORD_BITS-1:0]       coord_y_i,
  input  logic signed [COORD_BITS-1:0]       coord_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [$clog2(MAX_POINTS)-1:0]      neighbor_index_o,
  output logic [2*COORD_BITS+1:0]            neighbor_dist_sq_o,
  output logic [1:0]                         status_o,
  output logic                               last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [ksel_pkg::RAD_W-1:0]         cfg_data_i
);
  import ksel_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS+1);
  localparam int unsigned DIST_W = 2*COORD_BITS+2;
  localparam int unsigned BE_W   = IDX_W+DIST_W;
  localparam int unsigned SW     = (MAX_STENCIL > 1) ? $clog2(MAX_STENCIL) : 1;
  localparam int unsigned PT_W   = 3*COORD_BITS;

  function automatic logic bef(input logic [DIST_W-1:0] d, input logic [IDX_W-1:0] i,
                               input logic [BE_W-1:0] e);
    logic [DIST_W-1:0] ed;
    logic [IDX_W-1:0]  ei;
    ed = e[DIST_W-1:0];
    ei = e[BE_W-1:DIST_W];
    return (d < ed) || ((d == ed) && (i < ei));
  endfunction

  state_e state_q, state_d;

  logic [SIZE_W-1:0] size_q;
  logic [RAD_W-1:0]  radius_q;

  logic [PT_W-1:0] store_mem [MAX_POINTS];
  logic [PT_W-1:0] st_rdata_q;
  logic            st_we, st_re;
  logic [IDX_W-1:0] st_waddr, st_raddr;

  logic [BE_W-1:0] best_mem [MAX_STENCIL];
  logic [BE_W-1:0] bl_rdata_q, bl_wdata;
  logic            bl_we, bl_re;
  logic [SW-1:0]   bl_waddr, bl_raddr;

  logic [CNT_W-1:0] count_q, count_d, j_q, j_d;
  logic [IDX_W-1:0] c_q, c_d;
  logic [PT_W-1:0]  cen_q, cen_d;
  logic [SW:0]      n_q, n_d, k_q, k_d, m_q, m_d, nm1;
  logic [SW-1:0]    pos_q, pos_d, posm1;
  logic             end_q, end_d, held_v_q, held_v_d, pass;
  logic [BE_W-1:0]  held_q, held_d, cand;
  logic [IDX_W-1:0] resp_idx_q, resp_idx_d;
  status_e          resp_st_q, resp_st_d;

  logic              out_valid_q, out_valid_d, out_last_q, out_last_d, out_free;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d, dist_sum;
  status_e           out_st_q, out_st_d;

  dist_ctrl_t dctl;
  logic [CNT_W-1:0] kc;

  ksel_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dctl),
    .pt_i   (st_rdata_q),
    .cen_i  (cen_q),
    .dist_o (dist_sum)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign nm1   = n_q - (SW+1)'(1);
  assign posm1 = pos_q - SW'(1);
  assign cand  = {j_q[IDX_W-1:0], dist_sum};
  assign out_free = !out_valid_q || out_ready_i;
  assign pass = !end_q &&
    ({{RAD_W{1'b0}}, bl_rdata_q[DIST_W-1:0]} < {{DIST_W{1'b0}}, radius_q});

  always_comb begin
    int unsigned kt;
    kt = int'(size_q);
    if (kt < 1) kt = 1;
    if (kt > MAX_STENCIL) kt = MAX_STENCIL;
    if (kt > int'(count_q)) kt = int'(count_q);
    kc = CNT_W'(kt);
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    j_d        = j_q;
    c_d        = c_q;
    cen_d      = cen_q;
    n_d        = n_q;
    k_d        = k_q;
    m_d        = m_q;
    pos_d      = pos_q;
    end_d      = end_q;
    held_v_d   = held_v_q;
    held_d     = held_q;
    resp_idx_d = resp_idx_q;
    resp_st_d  = resp_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d  = out_idx_q;
    out_dist_d = out_dist_q;
    out_st_d   = out_st_q;
    out_last_d = out_last_q;
    st_we      = 1'b0;
    st_waddr   = count_q[IDX_W-1:0];
    st_re      = 1'b0;
    st_raddr   = j_q[IDX_W-1:0];
    bl_we      = 1'b0;
    bl_waddr   = pos_q;
    bl_wdata   = cand;
    bl_re      = 1'b0;
    bl_raddr   = posm1;
    dctl.op    = DOP_IDLE;
    dctl.axis  = AX_X;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (req_type_i)
            REQ_APPEND: begin
              state_d = S_RESP;
              if (count_q == CNT_W'(MAX_POINTS)) begin
                resp_idx_d = '0;
                resp_st_d  = ST_FULL;
              end else begin
                st_we      = 1'b1;
                resp_idx_d = count_q[IDX_W-1:0];
                resp_st_d  = ST_OK;
                count_d    = count_q + CNT_W'(1);
              end
            end
            REQ_QUERY: begin
              c_d = center_index_i;
              if (CNT_W'(center_index_i) >= count_q) begin
                resp_idx_d = center_index_i;
                resp_st_d  = ST_INVALID;
                state_d    = S_RESP;
              end else begin
                k_d      = (SW+1)'(kc);
                st_re    = 1'b1;
                st_raddr = center_index_i;
                state_d  = S_CEN;
              end
            end
            REQ_CLEAR: begin
              count_d    = '0;
              resp_idx_d = '0;
              resp_st_d  = ST_OK;
              state_d    = S_RESP;
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = resp_idx_q;
          out_dist_d  = '0;
          out_st_d    = resp_st_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_CEN: begin
        cen_d    = st_rdata_q;
        bl_we    = 1'b1;
        bl_waddr = '0;
        bl_wdata = {c_q, {DIST_W{1'b0}}};
        n_d      = (SW+1)'(1);
        j_d      = '0;
        state_d  = S_SC_RD;
      end
      S_SC_RD: begin
        if (j_q == count_q) begin
          m_d      = '0;
          held_v_d = 1'b0;
          state_d  = S_EM_RD;
        end else if (j_q == CNT_W'(c_q)) begin
          j_d = j_q + CNT_W'(1);
        end else begin
          st_re   = 1'b1;
          state_d = S_SC_X;
        end
      end
      S_SC_X: begin
        dctl.op = DOP_FIRST; dctl.axis = AX_X; state_d = S_SC_Y;
      end
      S_SC_Y: begin
        dctl.op = DOP_NEXT; dctl.axis = AX_Y; state_d = S_SC_Z;
      end
      S_SC_Z: begin
        dctl.op = DOP_NEXT; dctl.axis = AX_Z; state_d = S_SC_S;
      end
      S_SC_S: begin
        dctl.op = DOP_LAST; state_d = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (n_q < k_q) begin
          pos_d   = n_q[SW-1:0];
          n_d     = n_q + (SW+1)'(1);
          state_d = S_INS_RD;
        end else if (n_q > (SW+1)'(1)) begin
          bl_re    = 1'b1;
          bl_raddr = nm1[SW-1:0];
          state_d  = S_TAIL;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_SC_RD;
        end
      end
      S_TAIL: begin
        if (bef(dist_sum, j_q[IDX_W-1:0], bl_rdata_q)) begin
          pos_d   = nm1[SW-1:0];
          state_d = S_INS_RD;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_SC_RD;
        end
      end
      S_INS_RD: begin
        if (pos_q > SW'(1)) begin
          bl_re   = 1'b1;
          state_d = S_INS_CMP;
        end else begin
          bl_we   = 1'b1;
          j_d     = j_q + CNT_W'(1);
          state_d = S_SC_RD;
        end
      end
      S_INS_CMP: begin
        bl_we = 1'b1;
        if (bef(dist_sum, j_q[IDX_W-1:0], bl_rdata_q)) begin
          bl_wdata = bl_rdata_q;
          pos_d    = posm1;
          state_d  = S_INS_RD;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_SC_RD;
        end
      end
      S_EM_RD: begin
        if (m_q == n_q) begin
          end_d = 1'b1;
        end else begin
          end_d    = 1'b0;
          bl_re    = 1'b1;
          bl_raddr = m_q[SW-1:0];
        end
        state_d = S_EM_CHK;
      end
      S_EM_CHK: begin
        if (!held_v_q || out_free) begin
          if (held_v_q) begin
            out_valid_d = 1'b1;
            out_idx_d   = held_q[BE_W-1:DIST_W];
            out_dist_d  = held_q[DIST_W-1:0];
            out_st_d    = ST_OK;
            out_last_d  = !pass;
          end
          if (pass) begin
            held_d   = bl_rdata_q;
            held_v_d = 1'b1;
            m_d      = m_q + (SW+1)'(1);
            state_d  = S_EM_RD;
          end else begin
            held_v_d = 1'b0;
            state_d  = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      radius_q    <= RAD_RESET;
      count_q     <= '0;
      n_q         <= '0;
      m_q         <= '0;
      held_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SIZE:   size_q   <= cfg_data_i[SIZE_W-1:0];
          CFG_RADIUS: radius_q <= cfg_data_i;
          default: ;
        endcase
      end
      count_q     <= count_d;
      n_q         <= n_d;
      m_q         <= m_d;
      held_v_q    <= held_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q        <= j_d;
    c_q        <= c_d;
    cen_q      <= cen_d;
    k_q        <= k_d;
    pos_q      <= pos_d;
    end_q      <= end_d;
    held_q     <= held_d;
    resp_idx_q <= resp_idx_d;
    resp_st_q  <= resp_st_d;
    out_idx_q  <= out_idx_d;
    out_dist_q <= out_dist_d;
    out_st_q   <= out_st_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_waddr] <= {coord_z_i, coord_y_i, coord_x_i};
    if (st_re) st_rdata_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bl_we) best_mem[bl_waddr] <= bl_wdata;
    if (bl_re) bl_rdata_q <= best_mem[bl_raddr];
  end

  assign out_valid_o        = out_valid_q;
  assign neighbor_index_o   = out_idx_q;
  assign neighbor_dist_sq_o = out_dist_q;
  assign status_o           = out_st_q;
  assign last_o             = out_last_q;

endmodule

### hw/rtl/ksel_checker.sv
module ksel_checker #(
  parameter int unsigned MAX_POINTS = ksel_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = ksel_pkg::COORD_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [1:0]                    req_type_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [$clog2(MAX_POINTS)-1:0] neighbor_index_o,
  input logic [2*COORD_BITS+1:0]       neighbor_dist_sq_o,
  input logic [1:0]                    status_o,
  input logic                          last_o
);
  import ksel_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(neighbor_index_o)
      && $stable(neighbor_dist_sq_o) && $stable(status_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o)
    else $error("error beat not marked last");

  a_err_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> neighbor_dist_sq_o == '0)
    else $error("error beat carries a distance");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_APPEND || req_type_i == REQ_QUERY
      || req_type_i == REQ_CLEAR) |=> !in_ready_o)
    else $error("ready while a request is in progress");

endmodule

bind knn_stencil_select ksel_checker #(
  .MAX_POINTS (MAX_POINTS),
  .COORD_BITS (COORD_BITS)
) u_ksel_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .req_type_i         (req_type_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .neighbor_index_o   (neighbor_index_o),
  .neighbor_dist_sq_o (neighbor_dist_sq_o),
  .status_o           (status_o),
  .last_o             (last_o)
);
